[rtl/owb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owb_pkg
// Shared types and constants of the one-wire bus master: opcodes, sequencer
// phases, timing register indexes and defaults, and the result beat layout.
// ----------------------------------------------------------------------------
package owb_pkg;

  localparam int REG_W           = 10;
  localparam int CFG_IDX_W       = 3;
  localparam int NUM_REGS        = 6;
  localparam int TIMER_WIDTH_DEF = 10;
  localparam int BIT_IDX_W       = 3;

  localparam logic [REG_W-1:0] RESET_LOW_DEF     = 10'd500;
  localparam logic [REG_W-1:0] PRESENCE_WAIT_DEF = 10'd70;
  localparam logic [REG_W-1:0] RESET_TAIL_DEF    = 10'd500;
  localparam logic [REG_W-1:0] SLOT_LONG_DEF     = 10'd70;
  localparam logic [REG_W-1:0] SLOT_SHORT_DEF    = 10'd7;
  localparam logic [REG_W-1:0] READ_LOW_DEF      = 10'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRESENCE_WAIT = 3'd1,
    REG_RESET_TAIL    = 3'd2,
    REG_SLOT_LONG     = 3'd3,
    REG_SLOT_SHORT    = 3'd4,
    REG_READ_LOW      = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_HIGH = 4'd2,
    PH_RST_TAIL = 4'd3,
    PH_W_LOW    = 4'd4,
    PH_W_HIGH   = 4'd5,
    PH_R_LOW    = 4'd6,
    PH_R_HIGH   = 4'd7,
    PH_R_TAIL   = 4'd8
  } phase_t;

  typedef struct packed {
    logic       line_drive_enable;
    logic       line_drive_level;
    logic       busy_res;
    logic       done_res;
    logic       presence_ok;
    logic [7:0] read_value;
    logic       rejected;
  } rsp_t;

endpackage

[rtl/owb_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owb channel interfaces
// Valid/ready channels for commands, result beats and timing register writes.
// ----------------------------------------------------------------------------
interface owb_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;
  logic       line_sample;

  modport source (output valid, opcode, data_byte, line_sample, input ready);
  modport sink (input valid, opcode, data_byte, line_sample, output ready);
endinterface

interface owb_rsp_if;
  logic       valid;
  logic       ready;
  logic       line_drive_enable;
  logic       line_drive_level;
  logic       busy_res;
  logic       done_res;
  logic       presence_ok;
  logic [7:0] read_value;
  logic       rejected;

  modport source (output valid, line_drive_enable, line_drive_level, busy_res, done_res,
                  presence_ok, read_value, rejected, input ready);
  modport sink (input valid, line_drive_enable, line_drive_level, busy_res, done_res,
                presence_ok, read_value, rejected, output ready);
endinterface

interface owb_cfg_if import owb_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/one_wire_bus_master.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_bus_master
// One-wire bus master for a single dedicated line, timed by 1 us tick beats.
// ----------------------------------------------------------------------------
// cmd: one beat per tick (opcode tick) or per command (reset, write byte,
//   read byte), carrying the byte to send and the sampled line level.
//   Commands that arrive while an operation runs are answered with rejected.
// rsp: exactly one beat per cmd beat, in order: line drive enable and level,
//   busy, done pulse, presence result, last read byte, rejected.
// cfg: timing register writes, index 0..5, always ready; write only while
//   idle. Zero acts as one tick, values above the timer range saturate.
// Flow: rsp beats are registered, via the skid entry while rsp stalls.
//   Throughput is one cmd beat per cycle while cmd.ready is high.
// Stall: a result register plus one skid entry absorb a stalled rsp side;
//   cmd.ready drops only when the skid entry is occupied.
// Reset: timing registers return to 500/70/500/70/7/3 us, the sequencer goes
//   idle with the line released and level high, both buffers empty.
// ----------------------------------------------------------------------------
module one_wire_bus_master import owb_pkg::*; #(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  owb_cfg_if.sink   cfg,
  owb_cmd_if.sink   cmd,
  owb_rsp_if.source rsp
);

  logic [TIMER_WIDTH-1:0] dur [NUM_REGS];
  logic                   acc;
  rsp_t                   seq_res;
  rsp_t                   rsp_data;

  assign cfg.ready = 1'b1;
  assign acc       = cmd.valid & cmd.ready;

  owb_cfg_regs #(.TIMER_WIDTH(TIMER_WIDTH)) u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg.valid & cfg.ready),
    .idx   (cfg.index),
    .wdata (cfg.data),
    .dur   (dur)
  );

  owb_seq #(.TIMER_WIDTH(TIMER_WIDTH)) u_seq (
    .clk         (clk),
    .rst         (rst),
    .acc         (acc),
    .opcode      (cmd.opcode),
    .data_byte   (cmd.data_byte),
    .line_sample (cmd.line_sample),
    .dur         (dur),
    .res         (seq_res)
  );

  owb_rsp_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (acc),
    .in_data   (seq_res),
    .in_ready  (cmd.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  (rsp_data)
  );

  assign rsp.line_drive_enable = rsp_data.line_drive_enable;
  assign rsp.line_drive_level  = rsp_data.line_drive_level;
  assign rsp.busy_res          = rsp_data.busy_res;
  assign rsp.done_res          = rsp_data.done_res;
  assign rsp.presence_ok       = rsp_data.presence_ok;
  assign rsp.read_value        = rsp_data.read_value;
  assign rsp.rejected          = rsp_data.rejected;

endmodule

[rtl/owb_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owb_cfg_regs
// Timing register bank. Values are stored already fitted to the phase timer:
// zero becomes one, anything above the timer range saturates.
// ----------------------------------------------------------------------------
module owb_cfg_regs import owb_pkg::*; #(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   we,
  input  logic [CFG_IDX_W-1:0]   idx,
  input  logic [REG_W-1:0]       wdata,
  output logic [TIMER_WIDTH-1:0] dur [NUM_REGS]
);

  localparam int CMP_W = (REG_W > TIMER_WIDTH) ? REG_W : TIMER_WIDTH;
  localparam logic [CMP_W-1:0] TMAX = CMP_W'((1 << TIMER_WIDTH) - 1);

  function automatic logic [TIMER_WIDTH-1:0] clamp_dur(input logic [REG_W-1:0] v);
    logic [CMP_W-1:0] w;
    w = CMP_W'(v);
    if (w > TMAX) w = TMAX;
    if (w == '0) w = CMP_W'(1);
    return TIMER_WIDTH'(w);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      dur[REG_RESET_LOW]     <= clamp_dur(RESET_LOW_DEF);
      dur[REG_PRESENCE_WAIT] <= clamp_dur(PRESENCE_WAIT_DEF);
      dur[REG_RESET_TAIL]    <= clamp_dur(RESET_TAIL_DEF);
      dur[REG_SLOT_LONG]     <= clamp_dur(SLOT_LONG_DEF);
      dur[REG_SLOT_SHORT]    <= clamp_dur(SLOT_SHORT_DEF);
      dur[REG_READ_LOW]      <= clamp_dur(READ_LOW_DEF);
    end else if (we) begin
      case (reg_idx_t'(idx))
        REG_RESET_LOW:     dur[REG_RESET_LOW]     <= clamp_dur(wdata);
        REG_PRESENCE_WAIT: dur[REG_PRESENCE_WAIT] <= clamp_dur(wdata);
        REG_RESET_TAIL:    dur[REG_RESET_TAIL]    <= clamp_dur(wdata);
        REG_SLOT_LONG:     dur[REG_SLOT_LONG]     <= clamp_dur(wdata);
        REG_SLOT_SHORT:    dur[REG_SLOT_SHORT]    <= clamp_dur(wdata);
        REG_READ_LOW:      dur[REG_READ_LOW]      <= clamp_dur(wdata);
        default: ;
      endcase
    end
  end

endmodule

[rtl/owb_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owb_seq
// Bus sequencer: phase, timer, bit counter and shift byte, advanced by one
// accepted beat per cycle. Produces the result beat of that same beat.
// ----------------------------------------------------------------------------
module owb_seq import owb_pkg::*; #(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   acc,
  input  logic [1:0]             opcode,
  input  logic [7:0]             data_byte,
  input  logic                   line_sample,
  input  logic [TIMER_WIDTH-1:0] dur [NUM_REGS],
  output rsp_t                   res
);

  phase_t                 phase, phase_next;
  logic [TIMER_WIDTH-1:0] phase_timer, phase_timer_next;
  logic [BIT_IDX_W-1:0]   bit_index, bit_index_next;
  logic [7:0]             shift_byte, shift_byte_next;
  logic                   presence_seen, presence_seen_next;
  logic                   presence_result, presence_result_next;
  logic                   drive_en, drive_en_next;
  logic                   drive_lvl, drive_lvl_next;
  logic [7:0]             last_read, last_read_next;
  logic                   done_next;
  logic                   rejected_next;

  always_comb begin
    logic [7:0]           sh;
    logic [BIT_IDX_W-1:0] bi;
    phase_next           = phase;
    phase_timer_next     = phase_timer;
    bit_index_next       = bit_index;
    shift_byte_next      = shift_byte;
    presence_seen_next   = presence_seen;
    presence_result_next = presence_result;
    drive_en_next        = drive_en;
    drive_lvl_next       = drive_lvl;
    last_read_next       = last_read;
    done_next            = 1'b0;
    rejected_next        = 1'b0;
    sh                   = shift_byte >> 1;
    bi                   = bit_index + BIT_IDX_W'(1);
    if (acc) begin
      if (op_t'(opcode) == OP_TICK) begin
        if (phase != PH_IDLE) begin
          if (phase_timer <= TIMER_WIDTH'(1)) begin
            phase_timer_next = '0;
            case (phase)
              PH_RST_LOW: begin
                phase_next       = PH_RST_HIGH;
                drive_lvl_next   = 1'b1;
                phase_timer_next = dur[REG_PRESENCE_WAIT];
              end
              PH_RST_HIGH: begin
                drive_en_next      = 1'b0;
                presence_seen_next = ~line_sample;
                phase_next         = PH_RST_TAIL;
                phase_timer_next   = dur[REG_RESET_TAIL];
              end
              PH_RST_TAIL: begin
                presence_result_next = presence_seen & line_sample;
                phase_next           = PH_IDLE;
                done_next            = 1'b1;
              end
              PH_W_LOW: begin
                phase_next       = PH_W_HIGH;
                drive_lvl_next   = 1'b1;
                phase_timer_next = shift_byte[0] ? dur[REG_SLOT_LONG] : dur[REG_SLOT_SHORT];
              end
              PH_W_HIGH: begin
                shift_byte_next = sh;
                bit_index_next  = bi;
                if (bi == '0) begin
                  phase_next = PH_IDLE;
                  done_next  = 1'b1;
                end else begin
                  // next bit slot starts right away
                  phase_next       = PH_W_LOW;
                  drive_en_next    = 1'b1;
                  drive_lvl_next   = 1'b0;
                  phase_timer_next = sh[0] ? dur[REG_SLOT_SHORT] : dur[REG_SLOT_LONG];
                end
              end
              PH_R_LOW: begin
                phase_next       = PH_R_HIGH;
                drive_lvl_next   = 1'b1;
                phase_timer_next = dur[REG_SLOT_SHORT];
              end
              PH_R_HIGH: begin
                drive_en_next    = 1'b0;
                shift_byte_next  = {line_sample, shift_byte[7:1]};
                phase_next       = PH_R_TAIL;
                phase_timer_next = dur[REG_SLOT_LONG];
              end
              PH_R_TAIL: begin
                bit_index_next = bi;
                if (bi == '0) begin
                  last_read_next = shift_byte;
                  phase_next     = PH_IDLE;
                  done_next      = 1'b1;
                end else begin
                  phase_next       = PH_R_LOW;
                  drive_en_next    = 1'b1;
                  drive_lvl_next   = 1'b0;
                  phase_timer_next = dur[REG_READ_LOW];
                end
              end
              default: phase_next = PH_IDLE;
            endcase
          end else begin
            phase_timer_next = phase_timer - TIMER_WIDTH'(1);
          end
        end
      end else if (phase != PH_IDLE) begin
        rejected_next = 1'b1;
      end else begin
        drive_en_next  = 1'b1;
        drive_lvl_next = 1'b0;
        case (op_t'(opcode))
          OP_RESET: begin
            presence_seen_next = 1'b0;
            phase_next         = PH_RST_LOW;
            phase_timer_next   = dur[REG_RESET_LOW];
          end
          OP_WRITE: begin
            shift_byte_next  = data_byte;
            bit_index_next   = '0;
            phase_next       = PH_W_LOW;
            phase_timer_next = data_byte[0] ? dur[REG_SLOT_SHORT] : dur[REG_SLOT_LONG];
          end
          default: begin
            shift_byte_next  = '0;
            bit_index_next   = '0;
            phase_next       = PH_R_LOW;
            phase_timer_next = dur[REG_READ_LOW];
          end
        endcase
      end
    end
  end

  always_comb begin
    res.line_drive_enable = drive_en_next;
    res.line_drive_level  = drive_lvl_next;
    res.busy_res          = (phase_next != PH_IDLE);
    res.done_res          = done_next;
    res.presence_ok       = presence_result_next;
    res.read_value        = last_read_next;
    res.rejected          = rejected_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      phase_timer     <= '0;
      bit_index       <= '0;
      shift_byte      <= '0;
      presence_seen   <= 1'b0;
      presence_result <= 1'b0;
      drive_en        <= 1'b0;
      drive_lvl       <= 1'b1;
      last_read       <= '0;
    end else begin
      phase           <= phase_next;
      phase_timer     <= phase_timer_next;
      bit_index       <= bit_index_next;
      shift_byte      <= shift_byte_next;
      presence_seen   <= presence_seen_next;
      presence_result <= presence_result_next;
      drive_en        <= drive_en_next;
      drive_lvl       <= drive_lvl_next;
      last_read       <= last_read_next;
    end
  end

endmodule

[rtl/owb_rsp_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owb_rsp_buf
// Result register with one skid entry, so the command side can hand over one
// more beat while the result side stalls.
// ----------------------------------------------------------------------------
module owb_rsp_buf import owb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  rsp_t in_data,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

  logic o_valid;
  logic s_valid;
  rsp_t o_data;
  rsp_t s_data;

  assign in_ready  = ~s_valid;
  assign out_valid = o_valid;
  assign out_data  = o_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else if (out_ready || !o_valid) begin
      if (s_valid) begin
        o_valid <= 1'b1;
        s_valid <= 1'b0;
      end else begin
        o_valid <= in_valid;
      end
    end else if (in_valid) begin
      s_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !o_valid) begin
      if (s_valid) begin
        o_data <= s_data;
      end else if (in_valid) begin
        o_data <= in_data;
      end
    end else if (in_valid) begin
      s_data <= in_data;
    end
  end

endmodule

[rtl/owb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owb_port_props
// Port-level checks of the one-wire bus master, bound to the top level.
// ----------------------------------------------------------------------------
module owb_port_props (
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic busy_res,
  input logic done_res,
  input logic rejected,
  input logic line_drive_enable,
  input logic line_drive_level
);

  // a stalled beat stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp beat dropped while stalled");

  // buffers come out of reset empty
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("rsp beat offered right after reset");

  // completion leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && done_res |-> !busy_res && !rejected)
    else $error("done beat while still busy");

  // a rejected command only happens during a running operation
  a_rej_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rejected |-> busy_res)
    else $error("rejected beat while idle");

  // an idle sequencer never leaves the line pulled low
  a_idle_line: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !busy_res && line_drive_enable |-> line_drive_level)
    else $error("idle line driven low");

endmodule

bind one_wire_bus_master owb_port_props u_owb_port_props (
  .clk               (clk),
  .rst               (rst),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .busy_res          (rsp.busy_res),
  .done_res          (rsp.done_res),
  .rejected          (rsp.rejected),
  .line_drive_enable (rsp.line_drive_enable),
  .line_drive_level  (rsp.line_drive_level)
);

[test/owb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owb_checker
// Watches the timing register, command and result channels of the one-wire
// master, keeps its own copy of the bus sequencer, and compares every result
// beat, field by field, against the oldest predicted beat.
// ----------------------------------------------------------------------------
module owb_checker import owb_pkg::*; (
  input  logic clk,
  input  logic rst,
  owb_cfg_if   cfg,
  owb_cmd_if   cmd,
  owb_rsp_if   rsp,
  output int   errors,
  output int   pending
);

  localparam int unsigned TMR_MAX = (1 << TIMER_WIDTH_DEF) - 1;

  logic [REG_W-1:0] tm_reset_low, tm_presence_wait, tm_reset_tail;
  logic [REG_W-1:0] tm_slot_long, tm_slot_short, tm_read_low;

  phase_t      seq_phase;
  int unsigned ticks_left;
  logic [2:0]  bit_pos;
  logic [7:0]  shift_reg;
  logic [7:0]  last_byte;
  logic        presence_seen;
  logic        presence_flag;
  logic        drv_en;
  logic        drv_lvl;

  rsp_t bus_results_q[$];

  // zero counts as one tick, anything past the timer saturates
  function automatic int unsigned slot_len(logic [REG_W-1:0] v);
    int unsigned d;
    d = 32'(v);
    if (d > TMR_MAX) d = TMR_MAX;
    if (d == 0) d = 1;
    return d;
  endfunction

  function automatic void write_bit_start();
    seq_phase  = PH_W_LOW;
    drv_en     = 1'b1;
    drv_lvl    = 1'b0;
    ticks_left = slot_len(shift_reg[0] ? tm_slot_short : tm_slot_long);
  endfunction

  function automatic void read_bit_start();
    seq_phase  = PH_R_LOW;
    drv_en     = 1'b1;
    drv_lvl    = 1'b0;
    ticks_left = slot_len(tm_read_low);
  endfunction

  // current phase ran out on this tick; returns the done pulse
  function automatic logic phase_expired(logic line);
    logic done;
    done = 1'b0;
    case (seq_phase)
      PH_RST_LOW: begin
        seq_phase  = PH_RST_HIGH;
        drv_lvl    = 1'b1;
        ticks_left = slot_len(tm_presence_wait);
      end
      PH_RST_HIGH: begin
        drv_en        = 1'b0;
        presence_seen = !line;
        seq_phase     = PH_RST_TAIL;
        ticks_left    = slot_len(tm_reset_tail);
      end
      PH_RST_TAIL: begin
        presence_flag = presence_seen && line;
        seq_phase     = PH_IDLE;
        done          = 1'b1;
      end
      PH_W_LOW: begin
        seq_phase  = PH_W_HIGH;
        drv_lvl    = 1'b1;
        ticks_left = slot_len(shift_reg[0] ? tm_slot_long : tm_slot_short);
      end
      PH_W_HIGH: begin
        shift_reg = shift_reg >> 1;
        bit_pos   = bit_pos + 3'd1;
        if (bit_pos == 3'd0) begin
          seq_phase = PH_IDLE;
          done      = 1'b1;
        end else begin
          write_bit_start();
        end
      end
      PH_R_LOW: begin
        seq_phase  = PH_R_HIGH;
        drv_lvl    = 1'b1;
        ticks_left = slot_len(tm_slot_short);
      end
      PH_R_HIGH: begin
        drv_en     = 1'b0;
        shift_reg  = {line, shift_reg[7:1]};
        seq_phase  = PH_R_TAIL;
        ticks_left = slot_len(tm_slot_long);
      end
      PH_R_TAIL: begin
        bit_pos = bit_pos + 3'd1;
        if (bit_pos == 3'd0) begin
          last_byte = shift_reg;
          seq_phase = PH_IDLE;
          done      = 1'b1;
        end else begin
          read_bit_start();
        end
      end
      default: seq_phase = PH_IDLE;
    endcase
    return done;
  endfunction

  function automatic rsp_t bus_step(op_t op, logic [7:0] data, logic line);
    rsp_t r;
    logic done;
    logic rej;
    done = 1'b0;
    rej  = 1'b0;
    if (op == OP_TICK) begin
      if (seq_phase != PH_IDLE) begin
        if (ticks_left <= 1) begin
          ticks_left = 0;
          done = phase_expired(line);
        end else begin
          ticks_left--;
        end
      end
    end else if (seq_phase != PH_IDLE) begin
      rej = 1'b1;
    end else begin
      case (op)
        OP_RESET: begin
          presence_seen = 1'b0;
          seq_phase     = PH_RST_LOW;
          drv_en        = 1'b1;
          drv_lvl       = 1'b0;
          ticks_left    = slot_len(tm_reset_low);
        end
        OP_WRITE: begin
          shift_reg = data;
          bit_pos   = 3'd0;
          write_bit_start();
        end
        default: begin
          shift_reg = 8'h00;
          bit_pos   = 3'd0;
          read_bit_start();
        end
      endcase
    end
    r.line_drive_enable = drv_en;
    r.line_drive_level  = drv_lvl;
    r.busy_res          = (seq_phase != PH_IDLE);
    r.done_res          = done;
    r.presence_ok       = presence_flag;
    r.read_value        = last_byte;
    r.rejected          = rej;
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    rsp_t got;
    if (rst) begin
      tm_reset_low     = RESET_LOW_DEF;
      tm_presence_wait = PRESENCE_WAIT_DEF;
      tm_reset_tail    = RESET_TAIL_DEF;
      tm_slot_long     = SLOT_LONG_DEF;
      tm_slot_short    = SLOT_SHORT_DEF;
      tm_read_low      = READ_LOW_DEF;
      seq_phase        = PH_IDLE;
      ticks_left       = 0;
      bit_pos          = 3'd0;
      shift_reg        = 8'h00;
      last_byte        = 8'h00;
      presence_seen    = 1'b0;
      presence_flag    = 1'b0;
      drv_en           = 1'b0;
      drv_lvl          = 1'b1;
      errors           = 0;
      bus_results_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.line_drive_enable = rsp.line_drive_enable;
        got.line_drive_level  = rsp.line_drive_level;
        got.busy_res          = rsp.busy_res;
        got.done_res          = rsp.done_res;
        got.presence_ok       = rsp.presence_ok;
        got.read_value        = rsp.read_value;
        got.rejected          = rsp.rejected;
        if (bus_results_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("owb: result beat with nothing outstanding at %0t", $realtime);
        end else begin
          want = bus_results_q.pop_front();
          if (got.line_drive_enable !== want.line_drive_enable ||
              got.line_drive_level  !== want.line_drive_level  ||
              got.busy_res          !== want.busy_res          ||
              got.done_res          !== want.done_res          ||
              got.presence_ok       !== want.presence_ok       ||
              got.read_value        !== want.read_value        ||
              got.rejected          !== want.rejected) begin
            errors++;
            if (errors <= 10)
              $display("owb: mismatch at %0t:", $realtime,
                       " want en=%b lvl=%b busy=%b done=%b pres=%b rd=%h rej=%b,",
                       want.line_drive_enable, want.line_drive_level, want.busy_res,
                       want.done_res, want.presence_ok, want.read_value, want.rejected,
                       " got en=%b lvl=%b busy=%b done=%b pres=%b rd=%h rej=%b",
                       got.line_drive_enable, got.line_drive_level, got.busy_res,
                       got.done_res, got.presence_ok, got.read_value, got.rejected);
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (reg_idx_t'(cfg.index))
          REG_RESET_LOW:     tm_reset_low     = cfg.data;
          REG_PRESENCE_WAIT: tm_presence_wait = cfg.data;
          REG_RESET_TAIL:    tm_reset_tail    = cfg.data;
          REG_SLOT_LONG:     tm_slot_long     = cfg.data;
          REG_SLOT_SHORT:    tm_slot_short    = cfg.data;
          REG_READ_LOW:      tm_read_low      = cfg.data;
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready)
        bus_results_q.push_back(bus_step(op_t'(cmd.opcode), cmd.data_byte, cmd.line_sample));
    end
    pending = bus_results_q.size();
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the one-wire master with command and tick beats under several timing
// settings and idle patterns; the checker beside the block scores the results.
// ----------------------------------------------------------------------------
module testbench;
  import owb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int fail_count;
  int beats_owed;
  int gap_pct   = 0;
  int stall_pct = 0;
  int beats_sent = 0;

  // timing currently programmed, used to size tick runs
  int r_low  = int'(RESET_LOW_DEF);
  int p_wait = int'(PRESENCE_WAIT_DEF);
  int r_tail = int'(RESET_TAIL_DEF);
  int s_long = int'(SLOT_LONG_DEF);
  int s_short = int'(SLOT_SHORT_DEF);
  int rd_low = int'(READ_LOW_DEF);

  owb_cfg_if cfg_ch ();
  owb_cmd_if cmd_ch ();
  owb_rsp_if rsp_ch ();

  one_wire_bus_master dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  owb_checker chk (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .cmd     (cmd_ch),
    .rsp     (rsp_ch),
    .errors  (fail_count),
    .pending (beats_owed)
  );

  always #2 clk = ~clk;

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic int eff(int v);
    return (v == 0) ? 1 : v;
  endfunction

  // ticks needed to carry an operation from start to done
  function automatic int op_len(op_t op);
    case (op)
      OP_RESET: return eff(r_low) + eff(p_wait) + eff(r_tail);
      OP_WRITE: return 8 * (eff(s_long) + eff(s_short));
      OP_READ:  return 8 * (eff(rd_low) + eff(s_short) + eff(s_long));
      default:  return 0;
    endcase
  endfunction

  task automatic send_beat(op_t op, logic [7:0] data, logic line);
    while ($urandom_range(0, 99) < gap_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.opcode      <= op;
    cmd_ch.data_byte   <= data;
    cmd_ch.line_sample <= line;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic ticks_at(int n, logic line);
    repeat (n) send_beat(OP_TICK, 8'($urandom_range(0, 255)), line);
  endtask

  // ticks with a random line, now and then a stray command in between
  task automatic run_ticks(int n);
    repeat (n) begin
      if ($urandom_range(0, 99) < 3)
        send_beat(op_t'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      send_beat(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_random(int budget);
    int first;
    int n;
    op_t op;
    first = beats_sent;
    while (beats_sent - first < budget) begin
      op = op_t'($urandom_range(1, 3));
      send_beat(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      n = op_len(op) + $urandom_range(0, 2);
      // cut a sequence short once in a while
      if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);
      run_ticks(n);
    end
  endtask

  task automatic write_reg(reg_idx_t idx, logic [REG_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_regs(logic [REG_W-1:0] v_rl, logic [REG_W-1:0] v_pw,
                              logic [REG_W-1:0] v_rt, logic [REG_W-1:0] v_sl,
                              logic [REG_W-1:0] v_ss, logic [REG_W-1:0] v_rd);
    write_reg(REG_RESET_LOW, v_rl);
    write_reg(REG_PRESENCE_WAIT, v_pw);
    write_reg(REG_RESET_TAIL, v_rt);
    write_reg(REG_SLOT_LONG, v_sl);
    write_reg(REG_SLOT_SHORT, v_ss);
    write_reg(REG_READ_LOW, v_rd);
    cfg_ch.valid <= 1'b0;
    r_low = int'(v_rl);
    p_wait = int'(v_pw);
    r_tail = int'(v_rt);
    s_long = int'(v_sl);
    s_short = int'(v_ss);
    rd_low = int'(v_rd);
  endtask

  // hold the sender until every result beat is back
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (beats_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    cmd_ch.valid       = 1'b0;
    cmd_ch.opcode      = OP_TICK;
    cmd_ch.data_byte   = 8'h00;
    cmd_ch.line_sample = 1'b1;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_RESET_LOW;
    cfg_ch.data        = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // one byte at power-up timing
    send_beat(OP_WRITE, 8'h3C, 1'b1);
    run_ticks(op_len(OP_WRITE) + 1);
    drain();

    // short slots, slot_long at zero behaves as one tick
    program_regs(10'd1, 10'd1, 10'd1, 10'd0, 10'd1, 10'd1);
    send_beat(OP_TICK, 8'h00, 1'b0);
    send_beat(OP_RESET, 8'h00, 1'b1);
    send_beat(OP_READ, 8'hFF, 1'b0);
    ticks_at(1, 1'b1);
    ticks_at(1, 1'b0);
    ticks_at(1, 1'b1);
    // device answers but the line never recovers
    send_beat(OP_RESET, 8'hFF, 1'b1);
    ticks_at(1, 1'b1);
    ticks_at(2, 1'b0);
    send_beat(OP_WRITE, 8'hFF, 1'b0);
    send_beat(OP_WRITE, 8'h00, 1'b1);
    ticks_at(op_len(OP_WRITE), 1'b0);
    send_beat(OP_READ, 8'h00, 1'b1);
    ticks_at(op_len(OP_READ), 1'b1);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 83; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 83; end
        default: begin gap_pct = 32; stall_pct = 32; end
      endcase
      program_regs(REG_W'($urandom_range(0, 4)), REG_W'($urandom_range(0, 4)),
                   REG_W'($urandom_range(0, 4)), REG_W'($urandom_range(0, 4)),
                   REG_W'($urandom_range(0, 4)), REG_W'($urandom_range(0, 4)));
      run_random(40);
      drain();
    end

    // mid-range timing, one full reset sequence
    gap_pct = 0;
    stall_pct = 0;
    program_regs(10'd9, 10'd5, 10'd9, 10'd6, 10'd3, 10'd2);
    send_beat(OP_RESET, 8'h5A, 1'b1);
    run_ticks(op_len(OP_RESET) + 1);
    drain();

    if (fail_count == 0 && beats_owed == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

[sim.f]
rtl/owb_pkg.sv
rtl/owb_ifs.sv
rtl/owb_cfg_regs.sv
rtl/owb_seq.sv
rtl/owb_rsp_buf.sv
rtl/one_wire_bus_master.sv
rtl/owb_checker.sv
test/owb_checker.sv
test/testbench.sv
